FILE: design/cps_pkg.sv
`timescale 1ns / 1ps
package cps_pkg;
  localparam int MaxTasks = 64;
  localparam int MaxRels = 64;
  localparam int TaskAw = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int RelAw = (MaxRels > 1) ? $clog2(MaxRels) : 1;
  localparam int TaskCw = $clog2(MaxTasks + 1);
  localparam int RelCw = $clog2(MaxRels + 1);
  localparam logic [17:0] U18Max = 18'h3FFFF;
  localparam logic signed [20:0] S20Max = 21'sd524287;
  localparam logic signed [20:0] S20Min = -21'sd524288;

  typedef enum logic [1:0] {
    FUNC_TASK = 2'd0,
    FUNC_REL = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;
endpackage

FILE: design/critical_path_schedule.sv
`timescale 1ns / 1ps
// Critical-path scheduler.
// Issue a transaction with start high while busy is low: func selects a task
// load, a relation load or a compute. A load gives no result and leaves busy
// low, so loads can follow one per cycle. Loads beyond 64 tasks or 64
// relations are dropped.
// A compute runs its passes through add/compare logic on the two task read
// ports. The task stores have registered reads, so every (relation, task,
// task) triple goes through a read state and an update state. A compute holds
// busy high while it clears the start times, runs the forward pass, finds the
// total, seeds the latest finishes, runs the backward pass and emits; the
// passes are skipped with no relations. Each pass walks every pair of tasks
// for every relation.
// Results come out during the emit step, one after each read state, in load
// order, each marked by out_valid for exactly one cycle; out_last flags the
// final task. The receiver cannot stall the block. A compute with no tasks
// gives no result and does not raise busy. Both stores are emptied after the
// results.
// Reset (synchronous, rst_n low) empties both stores and returns to idle.
module critical_path_schedule (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_item_id,
  input  logic [15:0]        in_other_id,
  input  logic [11:0]        in_duration,
  output logic               out_valid,
  output logic [15:0]        out_task_id,
  output logic [17:0]        out_earliest_start,
  output logic [17:0]        out_earliest_finish,
  output logic signed [19:0] out_latest_start,
  output logic signed [19:0] out_latest_finish,
  output logic signed [19:0] out_slack,
  output logic               out_critical,
  output logic [17:0]        out_total_duration,
  output logic               out_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_FRD, S_FUPD, S_TRD, S_TACC, S_LSET, S_BRD, S_BUPD,
    S_ERD, S_EMIT
  } state_t;

  localparam int TAW = cps_pkg::TaskAw;
  localparam int RAW = cps_pkg::RelAw;
  localparam int TCW = cps_pkg::TaskCw;
  localparam int RCW = cps_pkg::RelCw;

  logic [15:0] tid_mem [cps_pkg::MaxTasks];
  logic [11:0] dur_mem [cps_pkg::MaxTasks];
  logic [17:0] es_mem  [cps_pkg::MaxTasks];
  logic signed [19:0] lf_mem [cps_pkg::MaxTasks];
  logic [15:0] suc_mem [cps_pkg::MaxRels];
  logic [15:0] pre_mem [cps_pkg::MaxRels];

  state_t state_r;
  logic [TCW-1:0] tcnt_r;
  logic [RCW-1:0] rcnt_r;
  logic [RCW-1:0] r_r;     // relation index
  logic [TCW-1:0] j_r, k_r;
  logic [17:0] total_r;

  // Registered read data from the stores.
  logic [15:0] tid_j_r, tid_k_r;
  logic [11:0] dur_j_r, dur_k_r;
  logic [17:0] es_j_r, es_k_r;
  logic signed [19:0] lf_j_r, lf_k_r;
  logic [15:0] suc_r, pre_r;

  logic [RAW-1:0] ridx;
  logic [TAW-1:0] jidx, kidx;
  assign ridx = r_r[RAW-1:0];
  assign jidx = j_r[TAW-1:0];
  assign kidx = k_r[TAW-1:0];

  // Shared unit: saturating finish/start computation for one task.
  logic [18:0] ef_sum;
  logic [17:0] ef_sat;
  logic signed [20:0] ls_diff;
  logic signed [19:0] ls_sat;
  assign ef_sum = {1'b0, es_j_r} + {7'd0, dur_j_r};
  assign ef_sat = ef_sum[18] ? cps_pkg::U18Max : ef_sum[17:0];
  assign ls_diff = {lf_j_r[19], lf_j_r} - $signed({9'd0, dur_j_r});
  assign ls_sat = (ls_diff > cps_pkg::S20Max) ? cps_pkg::S20Max[19:0] :
                  (ls_diff < cps_pkg::S20Min) ? cps_pkg::S20Min[19:0] : ls_diff[19:0];

  logic [18:0] k_ef_sum;
  logic [17:0] k_ef;
  logic signed [20:0] k_ls, k_sl;
  assign k_ef_sum = {1'b0, es_k_r} + {7'd0, dur_k_r};
  assign k_ef = k_ef_sum[18] ? cps_pkg::U18Max : k_ef_sum[17:0];
  assign k_ls = {lf_k_r[19], lf_k_r} - $signed({9'd0, dur_k_r});
  assign k_sl = {lf_k_r[19], lf_k_r} - $signed({3'd0, k_ef});

  function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
    logic signed [19:0] res;
    if (v > cps_pkg::S20Max) res = cps_pkg::S20Max[19:0];
    else if (v < cps_pkg::S20Min) res = cps_pkg::S20Min[19:0];
    else res = v[19:0];
    return res;
  endfunction

  logic jlast, klast;
  assign jlast = (j_r == tcnt_r - TCW'(1));
  assign klast = (k_r == tcnt_r - TCW'(1));

  logic signed [19:0] sl_o;
  assign sl_o = sat20(k_sl);

  // Two read ports per task store, one per relation store. Every update
  // cycle is preceded by a read cycle, so reads always see the last write.
  always_ff @(posedge clk) begin
    tid_j_r <= tid_mem[jidx];
    tid_k_r <= tid_mem[kidx];
    dur_j_r <= dur_mem[jidx];
    dur_k_r <= dur_mem[kidx];
    es_j_r <= es_mem[jidx];
    es_k_r <= es_mem[kidx];
    lf_j_r <= lf_mem[jidx];
    lf_k_r <= lf_mem[kidx];
    suc_r <= suc_mem[ridx];
    pre_r <= pre_mem[ridx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tcnt_r <= '0;
      rcnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            unique case (cps_pkg::func_t'(in_func))
              cps_pkg::FUNC_TASK: begin
                if (tcnt_r < TCW'(cps_pkg::MaxTasks)) begin
                  tid_mem[tcnt_r[TAW-1:0]] <= in_item_id;
                  dur_mem[tcnt_r[TAW-1:0]] <= in_duration;
                  tcnt_r <= tcnt_r + TCW'(1);
                end
              end
              cps_pkg::FUNC_REL: begin
                if (rcnt_r < RCW'(cps_pkg::MaxRels)) begin
                  suc_mem[rcnt_r[RAW-1:0]] <= in_item_id;
                  pre_mem[rcnt_r[RAW-1:0]] <= in_other_id;
                  rcnt_r <= rcnt_r + RCW'(1);
                end
              end
              cps_pkg::FUNC_COMPUTE: begin
                if (tcnt_r == '0) begin
                  rcnt_r <= '0;
                end else begin
                  j_r <= '0;
                  state_r <= S_INIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          es_mem[jidx] <= '0;
          j_r <= j_r + TCW'(1);
          if (jlast) begin
            j_r <= '0;
            k_r <= '0;
            r_r <= '0;
            state_r <= (rcnt_r == '0) ? S_TRD : S_FRD;
            total_r <= '0;
          end
        end
        S_FRD: state_r <= S_FUPD;
        S_FUPD: begin
          // Loop order: relation r, successor j, predecessor k.
          if (tid_j_r == suc_r && tid_k_r == pre_r && k_ef > es_j_r)
            es_mem[jidx] <= k_ef;
          state_r <= S_FRD;
          k_r <= k_r + TCW'(1);
          if (klast) begin
            k_r <= '0;
            j_r <= j_r + TCW'(1);
            if (jlast) begin
              j_r <= '0;
              r_r <= r_r + RCW'(1);
              if (r_r == rcnt_r - RCW'(1)) state_r <= S_TRD;
            end
          end
        end
        S_TRD: state_r <= S_TACC;
        S_TACC: begin
          if (ef_sat > total_r) total_r <= ef_sat;
          state_r <= S_TRD;
          j_r <= j_r + TCW'(1);
          if (jlast) begin
            j_r <= '0;
            state_r <= S_LSET;
          end
        end
        S_LSET: begin
          lf_mem[jidx] <= $signed({2'b00, total_r});
          j_r <= j_r + TCW'(1);
          if (jlast) begin
            j_r <= '0;
            k_r <= '0;
            r_r <= rcnt_r - RCW'(1);
            state_r <= (rcnt_r == '0) ? S_ERD : S_BRD;
          end
        end
        S_BRD: state_r <= S_BUPD;
        S_BUPD: begin
          if (tid_j_r == suc_r && tid_k_r == pre_r && ls_sat < lf_k_r)
            lf_mem[kidx] <= ls_sat;
          state_r <= S_BRD;
          k_r <= k_r + TCW'(1);
          if (klast) begin
            k_r <= '0;
            j_r <= j_r + TCW'(1);
            if (jlast) begin
              j_r <= '0;
              r_r <= r_r - RCW'(1);
              if (r_r == '0) state_r <= S_ERD;
            end
          end
        end
        S_ERD: state_r <= S_EMIT;
        S_EMIT: begin
          out_valid <= 1'b1;
          out_task_id <= tid_k_r;
          out_earliest_start <= es_k_r;
          out_earliest_finish <= k_ef;
          out_latest_start <= sat20(k_ls);
          out_latest_finish <= lf_k_r;
          out_slack <= sl_o;
          out_critical <= (sl_o == '0);
          out_total_duration <= total_r;
          out_last <= klast;
          k_r <= k_r + TCW'(1);
          state_r <= S_ERD;
          if (klast) begin
            tcnt_r <= '0;
            rcnt_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: design/cps_checker.sv
`timescale 1ns / 1ps
module cps_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic [1:0] in_func,
  input logic out_valid,
  input logic out_last,
  input logic out_critical,
  input logic signed [19:0] out_slack
);
  // A result is only registered while a compute is in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result outside compute");
  // The critical flag matches a zero slack.
  a_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_critical == (out_slack == '0))) else $error("critical flag");
  // After the final result the block returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy) else $error("not idle after last");
  // A load never makes the block busy.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == cps_pkg::FUNC_TASK || in_func == cps_pkg::FUNC_REL))
    |=> !busy) else $error("load made block busy");
endmodule

bind critical_path_schedule cps_checker u_cps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_func(in_func),
  .out_valid(out_valid), .out_last(out_last), .out_critical(out_critical),
  .out_slack(out_slack)
);
